@@ design/imm_pkg.sv @@
// Shared types and constants of the integer matrix multiplier.
// Used by imm_cell, imm_bmul and integer_matrix_multiply; depends on nothing.
`default_nettype none

package imm_pkg;

	localparam int IDX_W  = 4;
	localparam int DIM    = 16;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DATA_W = 32;

	// Kind of an input beat, carried in tuser.
	localparam logic REQ_LOAD_B = 1'b0;
	localparam logic REQ_A_ELEM = 1'b1;

	typedef logic [DATA_W-1:0] word_t;

	// Requests from the sequencer to the B store and multiplier.
	typedef struct packed {
		logic              load;
		logic [ADDR_W-1:0] load_addr;
		word_t             load_data;
		logic              rd;
		logic [ADDR_W-1:0] rd_addr;
	} bmul_req_t;

endpackage

`default_nettype wire

@@ design/imm_cell.sv @@
// One accumulator cell of the rotating chain.
// Depends on imm_pkg.
`default_nettype none

module imm_cell (
	input  wire logic          clk,
	input  wire logic          shift,
	input  wire imm_pkg::word_t nbr,
	output imm_pkg::word_t      q
);
	import imm_pkg::*;

	word_t acc_q;

	// Each cell takes its neighbor's word whenever the chain advances.
	always_ff @(posedge clk) begin
		if (shift) begin
			acc_q <= nbr;
		end
	end

	assign q = acc_q;

endmodule

`default_nettype wire

@@ design/imm_bmul.sv @@
// B matrix store and the shared multiplier: a registered memory read
// followed by a registered 32-bit product. Depends on imm_pkg.
`default_nettype none

module imm_bmul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire imm_pkg::bmul_req_t req,
	input  wire imm_pkg::word_t     a_value,
	output logic                    prod_valid,
	output imm_pkg::word_t          prod
);
	import imm_pkg::*;

	word_t b_mem [DIM*DIM];
	word_t b_s1;
	logic  rd_s1;
	word_t prod_s2;
	logic  valid_s2;

	always_ff @(posedge clk) begin
		if (req.load) begin
			b_mem[req.load_addr] <= req.load_data;
		end
		if (req.rd) begin
			b_s1 <= b_mem[req.rd_addr];
		end
		// Only the low word of the product is kept, as sums wrap modulo 2^32.
		prod_s2 <= DATA_W'(a_value * b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			rd_s1    <= req.rd;
			valid_s2 <= rd_s1;
		end
	end

	assign prod_valid = valid_s2;
	assign prod       = prod_s2;

endmodule

`default_nettype wire

@@ design/integer_matrix_multiply.sv @@
// Top level of the integer matrix multiplier: beat sequencer, B store with
// multiplier, and the rotating chain of row accumulator cells.
// Depends on imm_pkg, imm_cell and imm_bmul.

// Computes C = A * B for 16x16 signed 32-bit matrices, with all sums wrapping
// modulo 2^32. Send B first as load beats (tuser 0), one element per beat,
// each taking one cycle. Then send A row by row in ascending column order
// (tuser 1). An A element walks the 16 words of the matching B row through
// one shared multiplier and adds into the 16 accumulators, which rotate
// through a chain of cells once per product; the block holds off the input
// until the 16 reads of the B store have passed the read and multiply
// registers and all 16 products are added in. Column 0 starts the row
// afresh; column 15 then emits the C row as 16 output beats in column order
// with tlast on the final one, one beat per cycle while m_tready is high.
// Elements of B that were never loaded read as arbitrary values.
`default_nettype none

module integer_matrix_multiply (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // row[3:0], col[7:4], value[39:8]
	input  wire logic        s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // out_row[3:0], out_col[7:4], product_sum[39:8]
	output logic             m_tlast
);
	import imm_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_EMIT} state_t;

	localparam logic [IDX_W:0]   ISSUE_END = (IDX_W+1)'(DIM);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DIM - 1);

	state_t           state_q;
	word_t            v_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic             clr_q;
	logic             emit_q;
	logic [IDX_W:0]   iss_q;
	logic [IDX_W-1:0] add_q;
	logic [IDX_W-1:0] ocol_q;

	logic [IDX_W-1:0] in_row;
	logic [IDX_W-1:0] in_col;
	word_t            in_value;
	logic             accept;
	bmul_req_t        req;
	logic             prod_valid;
	word_t            prod;
	word_t            sum;
	word_t            tail_in;
	logic             shift;
	word_t            cell_q [DIM];

	assign in_row   = s_tdata[3:0];
	assign in_col   = s_tdata[7:4];
	assign in_value = s_tdata[39:8];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		req.load      = accept && (s_tuser == REQ_LOAD_B);
		req.load_addr = {in_row, in_col};
		req.load_data = in_value;
		req.rd        = (state_q == ST_MAC) && (iss_q < ISSUE_END);
		req.rd_addr   = {col_q, iss_q[IDX_W-1:0]};
	end

	imm_bmul u_bmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.a_value   (v_q),
		.prod_valid(prod_valid),
		.prod      (prod)
	);

	// The head of the chain meets the product for its column and the sum
	// re-enters at the tail; on emission the head simply wraps around.
	assign sum     = (clr_q ? '0 : cell_q[0]) + prod;
	assign tail_in = prod_valid ? sum : cell_q[0];
	assign shift   = prod_valid || ((state_q == ST_EMIT) && m_tready);

	for (genvar i = 0; i < DIM; i++) begin : g_cell
		word_t nbr;
		if (i == DIM - 1) begin : g_tail
			assign nbr = tail_in;
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end
		imm_cell u_cell (
			.clk  (clk),
			.shift(shift),
			.nbr  (nbr),
			.q    (cell_q[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == REQ_A_ELEM)) begin
			v_q   <= in_value;
			row_q <= in_row;
			col_q <= in_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q   <= 1'b0;
			emit_q  <= 1'b0;
			iss_q   <= '0;
			add_q   <= '0;
			ocol_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == REQ_A_ELEM)) begin
						state_q <= ST_MAC;
						clr_q   <= (in_col == '0);
						emit_q  <= (in_col == LAST_IDX);
						iss_q   <= '0;
						add_q   <= '0;
					end
				end
				ST_MAC: begin
					if (req.rd) begin
						iss_q <= iss_q + 1'b1;
					end
					if (prod_valid) begin
						add_q <= add_q + 1'b1;
						if (add_q == LAST_IDX) begin
							ocol_q  <= '0;
							state_q <= emit_q ? ST_EMIT : ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						ocol_q <= ocol_q + 1'b1;
						if (ocol_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {cell_q[0], ocol_q, row_q};
	assign m_tlast  = (ocol_q == LAST_IDX);

endmodule

`default_nettype wire
